// ----- rtl/tanh_soft_clipper_core_assert.svh -----
// assertion helpers shared by the clipper modules
`ifndef TANH_SOFT_CLIPPER_CORE_ASSERT_SVH
`define TANH_SOFT_CLIPPER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsc assertion failed");

// next-cycle implication, checked out of reset
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsc assertion failed");

`endif

// ----- rtl/tsc_pkg.sv -----
`default_nettype none

package tsc_pkg;

    // sample format
    localparam int SAMPLE_BITS = 24;
    localparam int SFRAC       = SAMPLE_BITS - 1;
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

    // register formats
    localparam int DRIVE_BITS = 24;
    localparam int RECIP_BITS = 30;
    localparam logic [DRIVE_BITS-1:0] DRIVE_MIN   = DRIVE_BITS'(7);
    localparam logic [DRIVE_BITS-1:0] DRIVE_RESET = DRIVE_BITS'(65536);
    localparam logic [RECIP_BITS-1:0] RECIP_RESET = RECIP_BITS'(86051);

    // apb register map
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam logic REG_DRIVE = 1'b0;
    localparam logic REG_RECIP = 1'b1;

    // tanh table
    localparam int TANH_TABLE_ENTRIES = 256;
    localparam int RANGE_BITS    = 3;
    localparam int ROM_FRAC      = 31;
    localparam int ROM_BITS      = ROM_FRAC + 1;
    localparam int IDX_BITS      = $clog2(TANH_TABLE_ENTRIES);
    localparam int ROM_ADDR_BITS = $clog2(TANH_TABLE_ENTRIES + 1);
    localparam int INTERP_BITS   = 16;
    localparam logic [ROM_BITS-1:0] ROM_ONE = ROM_BITS'(1) << ROM_FRAC;

    // datapath widths
    localparam int PROD_BITS   = SAMPLE_BITS + DRIVE_BITS;
    localparam int LIMIT_SHIFT = SFRAC + INTERP_BITS + RANGE_BITS;
    localparam int POS_BITS    = LIMIT_SHIFT + IDX_BITS;
    localparam int LERP_BITS   = ROM_BITS + INTERP_BITS;
    localparam int Y_BITS      = ROM_BITS + RECIP_BITS;
    localparam int ROUND_SHIFT = ROM_FRAC + INTERP_BITS - SFRAC;
    localparam int RES_BITS    = Y_BITS + 1 - ROUND_SHIFT;

    typedef logic [ROM_BITS-1:0] tanh_rom_t [0:TANH_TABLE_ENTRIES];

    // configuration seen by the datapath
    typedef struct packed {
        logic [DRIVE_BITS-1:0] drive;
        logic [RECIP_BITS-1:0] recip;
    } tsc_cfg_t;

    // table lookup request
    typedef struct packed {
        logic                   neg;
        logic                   sat;
        logic [IDX_BITS-1:0]    idx;
        logic [INTERP_BITS-1:0] frac;
    } tsc_idx_t;

    // interpolated tanh magnitude
    typedef struct packed {
        logic                neg;
        logic [ROM_BITS-1:0] tval;
    } tsc_tanh_t;

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          k;
        rem = '0;
        quo = '0;
        for (k = 63; k >= 0; k--)
        begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh table from the addition recurrence, series seed for the step
    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t   rom;
        logic [63:0] h;
        logic [63:0] h2;
        logic [63:0] h3;
        logic [63:0] h5;
        logic [63:0] h7;
        logic [63:0] th;
        logic [63:0] t;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] nt;
        int          i;
        h  = (64'd1 << (ROM_FRAC + RANGE_BITS)) / 64'(TANH_TABLE_ENTRIES);
        h2 = (h * h) >> ROM_FRAC;
        h3 = (h2 * h) >> ROM_FRAC;
        h5 = (h3 * h2) >> ROM_FRAC;
        h7 = (h5 * h2) >> ROM_FRAC;
        th = (h + (64'd2 * h5) / 64'd15) - (h3 / 64'd3 + (64'd17 * h7) / 64'd315);
        t  = '0;
        rom[0] = '0;
        for (i = 1; i <= TANH_TABLE_ENTRIES; i++)
        begin
            num = (t + th) << ROM_FRAC;
            den = 64'(ROM_ONE) + ((t * th) >> ROM_FRAC);
            nt  = udiv64(num, den);
            if (nt > 64'(ROM_ONE))
            begin
                nt = 64'(ROM_ONE);
            end
            if (nt < t)
            begin
                nt = t;
            end
            t      = nt;
            rom[i] = ROM_BITS'(t);
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

`default_nettype wire

// ----- rtl/tanh_soft_clipper_core.sv -----
// channel   direction  signals                      contents
// s_*       in         tvalid tready tdata[23:0]    audio_in, signed Q1.23
// m_*       out        tvalid tready tdata[23:0]    audio_out, signed Q1.23
// apb       in/out     psel penable pwrite paddr    drive_gain at 0, norm_reciprocal at 4
//
// one sample per cycle while m_tready is high; m_tvalid is the valid bit of the last stage
// the seven stages are: drive multiply, table position, table read, slope multiply,
// interpolate, reciprocal multiply, round and saturate
// every stage has its own valid bit and takes a new request when empty or moving on,
// so bubbles close up while m_tready is low and nothing is lost or repeated
// rst_n clears the valid bits and loads drive 1.0 and reciprocal 1/tanh(1.0)
`default_nettype none

module tanh_soft_clipper_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // slave stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tsc_pkg::TDATA_BITS-1:0]    s_tdata,   // [23:0] audio_in
    // master stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [tsc_pkg::TDATA_BITS-1:0]    m_tdata,   // [23:0] audio_out
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tsc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [tsc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [tsc_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                   pready
);

    tsc_pkg::tsc_cfg_t               cfg;
    logic                            idx_valid;
    logic                            idx_ready;
    tsc_pkg::tsc_idx_t               idx_data;
    logic                            tanh_valid;
    logic                            tanh_ready;
    tsc_pkg::tsc_tanh_t              tanh_data;
    logic [tsc_pkg::SAMPLE_BITS-1:0] audio_out;

    assign pready = 1'b1;

    // register file
    tsc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // drive and table position
    tsc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .sample    (s_tdata[tsc_pkg::SAMPLE_BITS-1:0]),
        .out_valid (idx_valid),
        .out_ready (idx_ready),
        .out_data  (idx_data)
    );

    // table lookup and interpolation
    tsc_interp u_interp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (idx_valid),
        .in_ready  (idx_ready),
        .in_data   (idx_data),
        .out_valid (tanh_valid),
        .out_ready (tanh_ready),
        .out_data  (tanh_data)
    );

    // normalization and output register
    tsc_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (tanh_valid),
        .in_ready  (tanh_ready),
        .in_data   (tanh_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (audio_out)
    );

    assign m_tdata = tsc_pkg::TDATA_BITS'(audio_out);

endmodule

`default_nettype wire

// ----- rtl/tsc_regs.sv -----
`default_nettype none

module tsc_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tsc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [tsc_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [tsc_pkg::CFG_DATA_BITS-1:0] prdata,
    output tsc_pkg::tsc_cfg_t                      cfg
);

    logic [tsc_pkg::DRIVE_BITS-1:0] drive_reg;
    logic [tsc_pkg::DRIVE_BITS-1:0] drive_next;
    logic [tsc_pkg::DRIVE_BITS-1:0] drive_wr;
    logic [tsc_pkg::RECIP_BITS-1:0] recip_reg;
    logic [tsc_pkg::RECIP_BITS-1:0] recip_next;
    logic                           wr_en;
    logic                           reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[tsc_pkg::CFG_ADDR_BITS-1];

    // drive writes below the floor are clamped
    assign drive_wr = pwdata[tsc_pkg::DRIVE_BITS-1:0];

    // write decode
    always_comb
    begin
        drive_next = drive_reg;
        recip_next = recip_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                tsc_pkg::REG_DRIVE:
                begin
                    drive_next = (drive_wr < tsc_pkg::DRIVE_MIN) ? tsc_pkg::DRIVE_MIN : drive_wr;
                end
                tsc_pkg::REG_RECIP:
                begin
                    recip_next = pwdata[tsc_pkg::RECIP_BITS-1:0];
                end
                default:
                begin
                    recip_next = recip_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= tsc_pkg::DRIVE_RESET;
            recip_reg <= tsc_pkg::RECIP_RESET;
        end
        else
        begin
            drive_reg <= drive_next;
            recip_reg <= recip_next;
        end
    end

    // read decode
    always_comb
    begin
        unique case (reg_sel)
            tsc_pkg::REG_DRIVE: prdata = tsc_pkg::CFG_DATA_BITS'(drive_reg);
            tsc_pkg::REG_RECIP: prdata = tsc_pkg::CFG_DATA_BITS'(recip_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.drive = drive_reg;
    assign cfg.recip = recip_reg;

`include "tanh_soft_clipper_core_assert.svh"

    `TSC_ASSERT_IMPL(a_drive_floor, clk, rst_n, 1'b1, drive_reg >= tsc_pkg::DRIVE_MIN)

endmodule

`default_nettype wire

// ----- rtl/tsc_front.sv -----
`default_nettype none

module tsc_front
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tsc_pkg::tsc_cfg_t               cfg,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [tsc_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output tsc_pkg::tsc_idx_t                    out_data
);

    // stage a: magnitude times drive
    logic                                v_a_reg;
    logic                                neg_a_reg;
    logic [tsc_pkg::PROD_BITS-1:0]       p_a_reg;
    logic [tsc_pkg::SAMPLE_BITS-1:0]     mag;
    logic [tsc_pkg::PROD_BITS-1:0]       p_a_next;
    logic                                ready_a;

    // stage b: range check and table position
    logic                                v_b_reg;
    tsc_pkg::tsc_idx_t                   idx_b_reg;
    tsc_pkg::tsc_idx_t                   idx_b_next;
    logic [tsc_pkg::POS_BITS-1:0]        pos;
    logic                                ready_b;

    assign ready_b  = !v_b_reg || out_ready;
    assign ready_a  = !v_a_reg || ready_b;
    assign in_ready = ready_a;

    // most negative sample maps to a magnitude of exactly one
    assign mag      = sample[tsc_pkg::SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    assign p_a_next = tsc_pkg::PROD_BITS'(mag) * tsc_pkg::PROD_BITS'(cfg.drive);

    // table position is the argument scaled by entries per unit range
    assign pos = tsc_pkg::POS_BITS'(p_a_reg[tsc_pkg::LIMIT_SHIFT-1:0])
               * tsc_pkg::POS_BITS'(tsc_pkg::TANH_TABLE_ENTRIES);

    always_comb
    begin
        idx_b_next.neg  = neg_a_reg;
        idx_b_next.sat  = |p_a_reg[tsc_pkg::PROD_BITS-1:tsc_pkg::LIMIT_SHIFT];
        idx_b_next.idx  = pos[tsc_pkg::POS_BITS-1:tsc_pkg::LIMIT_SHIFT];
        idx_b_next.frac = pos[tsc_pkg::LIMIT_SHIFT-1 -: tsc_pkg::INTERP_BITS];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                v_a_reg <= in_valid;
            end
            if (ready_b)
            begin
                v_b_reg <= v_a_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            neg_a_reg <= sample[tsc_pkg::SAMPLE_BITS-1];
            p_a_reg   <= p_a_next;
        end
        if (ready_b && v_a_reg)
        begin
            idx_b_reg <= idx_b_next;
        end
    end

    assign out_valid = v_b_reg;
    assign out_data  = idx_b_reg;

endmodule

`default_nettype wire

// ----- rtl/tsc_interp.sv -----
`default_nettype none

module tsc_interp
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tsc_pkg::tsc_idx_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tsc_pkg::tsc_tanh_t out_data
);

    // stage c: table reads
    logic                               v_c_reg;
    logic                               neg_c_reg;
    logic                               sat_c_reg;
    logic [tsc_pkg::ROM_BITS-1:0]       lo_c_reg;
    logic [tsc_pkg::ROM_BITS-1:0]       hi_c_reg;
    logic [tsc_pkg::INTERP_BITS-1:0]    frac_c_reg;
    logic [tsc_pkg::ROM_ADDR_BITS-1:0]  addr_lo;
    logic [tsc_pkg::ROM_ADDR_BITS-1:0]  addr_hi;
    logic                               ready_c;

    // stage d: slope times fraction
    logic                               v_d_reg;
    logic                               neg_d_reg;
    logic                               sat_d_reg;
    logic [tsc_pkg::ROM_BITS-1:0]       lo_d_reg;
    logic [tsc_pkg::LERP_BITS-1:0]      lerp_d_reg;
    logic [tsc_pkg::LERP_BITS-1:0]      lerp_d_next;
    logic                               ready_d;

    // stage e: interpolated value
    logic                               v_e_reg;
    logic                               neg_e_reg;
    logic [tsc_pkg::ROM_BITS-1:0]       t_e_reg;
    logic [tsc_pkg::ROM_BITS-1:0]       t_e_next;
    logic                               ready_e;

    assign ready_e  = !v_e_reg || out_ready;
    assign ready_d  = !v_d_reg || ready_e;
    assign ready_c  = !v_c_reg || ready_d;
    assign in_ready = ready_c;

    assign addr_lo = tsc_pkg::ROM_ADDR_BITS'(in_data.idx);
    assign addr_hi = addr_lo + 1'b1;

    // table is monotone, so the slope is never negative
    assign lerp_d_next = tsc_pkg::LERP_BITS'(hi_c_reg - lo_c_reg)
                       * tsc_pkg::LERP_BITS'(frac_c_reg);

    // beyond the table tanh is exactly one
    assign t_e_next = sat_d_reg ? tsc_pkg::ROM_ONE
                    : lo_d_reg + lerp_d_reg[tsc_pkg::LERP_BITS-1:tsc_pkg::INTERP_BITS];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
            v_e_reg <= 1'b0;
        end
        else
        begin
            if (ready_c)
            begin
                v_c_reg <= in_valid;
            end
            if (ready_d)
            begin
                v_d_reg <= v_c_reg;
            end
            if (ready_e)
            begin
                v_e_reg <= v_d_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready_c && in_valid)
        begin
            neg_c_reg  <= in_data.neg;
            sat_c_reg  <= in_data.sat;
            lo_c_reg   <= tsc_pkg::TANH_ROM[addr_lo];
            hi_c_reg   <= tsc_pkg::TANH_ROM[addr_hi];
            frac_c_reg <= in_data.frac;
        end
        if (ready_d && v_c_reg)
        begin
            neg_d_reg  <= neg_c_reg;
            sat_d_reg  <= sat_c_reg;
            lo_d_reg   <= lo_c_reg;
            lerp_d_reg <= lerp_d_next;
        end
        if (ready_e && v_d_reg)
        begin
            neg_e_reg <= neg_d_reg;
            t_e_reg   <= t_e_next;
        end
    end

    assign out_valid     = v_e_reg;
    assign out_data.neg  = neg_e_reg;
    assign out_data.tval = t_e_reg;

`include "tanh_soft_clipper_core_assert.svh"

    `TSC_ASSERT_IMPL(a_tanh_le_one, clk, rst_n, v_e_reg, t_e_reg <= tsc_pkg::ROM_ONE)
    `TSC_ASSERT_NEXT(a_lerp_moves, clk, rst_n, v_d_reg && ready_e, v_e_reg)

endmodule

`default_nettype wire

// ----- rtl/tsc_scale.sv -----
`default_nettype none

module tsc_scale
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tsc_pkg::tsc_cfg_t           cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire tsc_pkg::tsc_tanh_t          in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tsc_pkg::SAMPLE_BITS-1:0]  out_data
);

    // stage f: normalization product
    logic                              v_f_reg;
    logic                              neg_f_reg;
    logic [tsc_pkg::Y_BITS-1:0]        y_f_reg;
    logic [tsc_pkg::Y_BITS-1:0]        y_f_next;
    logic                              ready_f;

    // stage g: round, saturate, restore sign
    logic                              v_g_reg;
    logic                              neg_g_reg;
    logic [tsc_pkg::SAMPLE_BITS-1:0]   out_g_reg;
    logic [tsc_pkg::SAMPLE_BITS-1:0]   out_g_next;
    logic [tsc_pkg::Y_BITS:0]          y_round;
    logic [tsc_pkg::RES_BITS-1:0]      res;
    logic [tsc_pkg::RES_BITS-1:0]      res_lim;
    logic [tsc_pkg::SAMPLE_BITS-1:0]   res_mag;
    logic                              ready_g;

    assign ready_g  = !v_g_reg || out_ready;
    assign ready_f  = !v_f_reg || ready_g;
    assign in_ready = ready_f;

    assign y_f_next = tsc_pkg::Y_BITS'(in_data.tval) * tsc_pkg::Y_BITS'(cfg.recip);

    // round half away from zero on the magnitude
    assign y_round = {1'b0, y_f_reg}
                   + ((tsc_pkg::Y_BITS + 1)'(1) << (tsc_pkg::ROUND_SHIFT - 1));
    assign res     = y_round[tsc_pkg::Y_BITS:tsc_pkg::ROUND_SHIFT];

    // negative side reaches one step further
    assign res_lim = neg_f_reg ? (tsc_pkg::RES_BITS'(1) << tsc_pkg::SFRAC)
                               : ((tsc_pkg::RES_BITS'(1) << tsc_pkg::SFRAC) - 1'b1);
    assign res_mag = (res > res_lim) ? tsc_pkg::SAMPLE_BITS'(res_lim)
                                     : tsc_pkg::SAMPLE_BITS'(res);

    assign out_g_next = neg_f_reg ? (~res_mag + 1'b1) : res_mag;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_f_reg <= 1'b0;
            v_g_reg <= 1'b0;
        end
        else
        begin
            if (ready_f)
            begin
                v_f_reg <= in_valid;
            end
            if (ready_g)
            begin
                v_g_reg <= v_f_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready_f && in_valid)
        begin
            neg_f_reg <= in_data.neg;
            y_f_reg   <= y_f_next;
        end
        if (ready_g && v_f_reg)
        begin
            neg_g_reg <= neg_f_reg;
            out_g_reg <= out_g_next;
        end
    end

    assign out_valid = v_g_reg;
    assign out_data  = out_g_reg;

`include "tanh_soft_clipper_core_assert.svh"

    `TSC_ASSERT_IMPL(a_pos_sign, clk, rst_n, v_g_reg && !neg_g_reg, !out_g_reg[tsc_pkg::SAMPLE_BITS-1])
    `TSC_ASSERT_IMPL(a_neg_sign, clk, rst_n, v_g_reg && neg_g_reg, out_g_reg[tsc_pkg::SAMPLE_BITS-1] || (out_g_reg == '0))

endmodule

`default_nettype wire
